[hw/rtl/shs_pkg.sv]
`timescale 1ns / 1ps

package shs_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned NumWords   = 8;
  localparam int unsigned WindowW    = 512;

  // Input action codes. The unused code behaves as a finish without byte.
  localparam logic [1:0] ACT_ABSORB     = 2'd0;
  localparam logic [1:0] ACT_ABSORB_FIN = 2'd1;
  localparam logic [1:0] ACT_FINISH     = 2'd2;

  localparam logic [7:0]  PadMarker     = 8'h80;
  localparam logic [5:0]  LenFieldStart = 6'd56;
  localparam logic [5:0]  LastByteSlot  = 6'd63;
  localparam logic [5:0]  LastRound     = 6'd63;
  localparam logic [2:0]  LastWordIdx   = 3'd7;
  localparam logic [63:0] BlockBits     = 64'd512;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       load_vars;
    logic       run_round;
    logic [5:0] round;
  } core_ctrl_t;

  function automatic word_t initial_hash(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_const(input logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/sha256_stream_hasher.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Beat contents
// in        in         in_valid_i/in_ready_o   action, data_byte
// out       out        out_valid_o/out_ready_i digest_word, word_index, last_word
//
// A byte that does not complete a block or finish the message leaves the input
// ready. The 64th byte of a block starts the round unit: it runs the 64 rounds,
// then a fold step adds the result into the hash words.
// A finish pushes padding and length bytes one per cycle (up to 64 per block,
// one or two blocks, each followed by compression), then offers the eight
// digest words as eight output beats.
// Reset loads the initial hash values and clears the counters; no clearing
// pass is needed. The input is not ready from the 64th byte of a block until its
// result is added into the hash words or, after a finish, until the last
// digest beat is taken; a stalled output simply holds.
module sha256_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shs_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shs_pkg::out_beat_t out_data_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bit_total_q, bit_total_d;
  logic [63:0] len_q, len_d;
  logic        fin_q, fin_d;
  logic        marker_q, marker_d;
  logic        lenmode_q, lenmode_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;

  shs_pkg::word_t [shs_pkg::NumWords-1:0] hash_q, hash_d, vars;
  shs_pkg::core_ctrl_t                    ctrl;

  logic in_acc, out_acc, has_byte, wants_fin;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;

  // Action codes other than the two absorbing ones carry no byte.
  assign has_byte  = (in_data_i.action == shs_pkg::ACT_ABSORB) ||
                     (in_data_i.action == shs_pkg::ACT_ABSORB_FIN);
  assign wants_fin = (in_data_i.action != shs_pkg::ACT_ABSORB);

  assign out_data_o.digest_word = hash_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.last_word   = (out_idx_q == shs_pkg::LastWordIdx);

  shs_core u_core (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .hash_i (hash_q),
    .vars_o (vars)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bit_total_d = bit_total_q;
    len_d       = len_q;
    fin_d       = fin_q;
    marker_d    = marker_q;
    lenmode_d   = lenmode_q;
    round_d     = round_q;
    out_idx_d   = out_idx_q;
    hash_d      = hash_q;
    ctrl        = '0;
    ctrl.round  = round_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          fin_d     = wants_fin;
          marker_d  = 1'b0;
          lenmode_d = 1'b0;
          if (has_byte) begin
            ctrl.shift_byte = 1'b1;
            ctrl.byte_val   = in_data_i.data_byte;
            fill_d          = fill_q + 6'd1;
            if (fill_q == shs_pkg::LastByteSlot) begin
              // The block is full: the length only counts completed blocks here.
              bit_total_d    = bit_total_q + shs_pkg::BlockBits;
              ctrl.load_vars = 1'b1;
              round_d        = '0;
              state_d        = ST_COMP;
            end else if (wants_fin) begin
              state_d = ST_PAD;
            end
          end else begin
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // One padding byte per cycle: the marker, then zeros, then the length.
        ctrl.shift_byte = 1'b1;
        fill_d          = fill_q + 6'd1;
        if (!marker_q) begin
          ctrl.byte_val = shs_pkg::PadMarker;
          marker_d      = 1'b1;
          len_d         = bit_total_q + {55'd0, fill_q, 3'd0};
        end else if (lenmode_q || (fill_q == shs_pkg::LenFieldStart)) begin
          ctrl.byte_val = len_q[63:56];
          len_d         = {len_q[55:0], 8'h00};
          lenmode_d     = 1'b1;
        end else begin
          ctrl.byte_val = 8'h00;
        end
        if (fill_q == shs_pkg::LastByteSlot) begin
          ctrl.load_vars = 1'b1;
          round_d        = '0;
          state_d        = ST_COMP;
        end
      end

      ST_COMP: begin
        ctrl.run_round = 1'b1;
        round_d        = round_q + 6'd1;
        if (round_q == shs_pkg::LastRound) begin
          state_d = ST_FOLD;
        end
      end

      ST_FOLD: begin
        for (int i = 0; i < shs_pkg::NumWords; i++) begin
          hash_d[i] = hash_q[i] + vars[i];
        end
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (lenmode_q) begin
          out_idx_d = '0;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == shs_pkg::LastWordIdx) begin
            for (int i = 0; i < shs_pkg::NumWords; i++) begin
              hash_d[i] = shs_pkg::initial_hash(3'(i));
            end
            bit_total_d = '0;
            fin_d       = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bit_total_q <= '0;
      len_q       <= '0;
      fin_q       <= 1'b0;
      marker_q    <= 1'b0;
      lenmode_q   <= 1'b0;
      round_q     <= '0;
      out_idx_q   <= '0;
      for (int i = 0; i < shs_pkg::NumWords; i++) begin
        hash_q[i] <= shs_pkg::initial_hash(3'(i));
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bit_total_q <= bit_total_d;
      len_q       <= len_d;
      fin_q       <= fin_d;
      marker_q    <= marker_d;
      lenmode_q   <= lenmode_d;
      round_q     <= round_d;
      out_idx_q   <= out_idx_d;
      hash_q      <= hash_d;
    end
  end

  // The length field is only ever written after the marker byte.
  a_len_after_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lenmode_q |-> marker_q)
    else $error("length bytes started before the pad marker");

  // Compression starts only after the last byte slot of a block was filled.
  a_comp_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP) && (round_q == 6'd0) |-> $past(fill_q) == shs_pkg::LastByteSlot)
    else $error("compression started on a partial block");

  // The hash is folded only after all 64 rounds.
  a_fold_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |->
      ($past(state_q) == ST_COMP) && ($past(round_q) == shs_pkg::LastRound))
    else $error("hash folded before the last round");

  // The digest is offered only with the final block complete.
  a_out_block_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_q == 6'd0) && lenmode_q && fin_q)
    else $error("digest offered with padding incomplete");

  // After the last digest beat the block is back at the initial state.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.last_word |=>
      in_ready_o && (bit_total_q == 64'd0) && (hash_q[0] == shs_pkg::initial_hash(3'd0)))
    else $error("hash state not restored after the digest");

endmodule

[hw/rtl/shs_core.sv]
`timescale 1ns / 1ps

// One SHA-256 round per cycle while run_round is set. The 512-bit window first collects the block
// bytes and then serves as the rolling 16-word message schedule.
module shs_core (
  input  logic                                           clk_i,
  input  shs_pkg::core_ctrl_t                            ctrl_i,
  input  shs_pkg::word_t [shs_pkg::NumWords-1:0]         hash_i,
  output shs_pkg::word_t [shs_pkg::NumWords-1:0]         vars_o
);

  logic [shs_pkg::WindowW-1:0]            window_q, window_d;
  shs_pkg::word_t [shs_pkg::NumWords-1:0] vars_q, vars_d;

  shs_pkg::word_t w_cur, w_1, w_9, w_14, w_new;
  shs_pkg::word_t s0_w, s1_w, s0_v, s1_v, ch, maj, t1, t2;

  function automatic shs_pkg::word_t ror(input shs_pkg::word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Word i of the window sits at the top end for i = 0.
  assign w_cur = window_q[511:480];
  assign w_1   = window_q[479:448];
  assign w_9   = window_q[223:192];
  assign w_14  = window_q[63:32];

  assign s0_w  = ror(w_1, 7) ^ ror(w_1, 18) ^ (w_1 >> 3);
  assign s1_w  = ror(w_14, 17) ^ ror(w_14, 19) ^ (w_14 >> 10);
  assign w_new = s1_w + w_9 + s0_w + w_cur;

  assign s1_v = ror(vars_q[4], 6) ^ ror(vars_q[4], 11) ^ ror(vars_q[4], 25);
  assign ch   = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign s0_v = ror(vars_q[0], 2) ^ ror(vars_q[0], 13) ^ ror(vars_q[0], 22);
  assign maj  = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^
                (vars_q[1] & vars_q[2]);
  assign t1   = vars_q[7] + s1_v + ch + shs_pkg::round_const(ctrl_i.round) + w_cur;
  assign t2   = s0_v + maj;

  always_comb begin
    window_d = window_q;
    if (ctrl_i.shift_byte) begin
      window_d = {window_q[503:0], ctrl_i.byte_val};
    end else if (ctrl_i.run_round) begin
      window_d = {window_q[479:0], w_new};
    end
  end

  always_comb begin
    vars_d = vars_q;
    if (ctrl_i.load_vars) begin
      vars_d = hash_i;
    end else if (ctrl_i.run_round) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    vars_q   <= vars_d;
  end

  assign vars_o = vars_q;

endmodule
